// File: design/snv_pkg.sv
// Shared types and constants for the sorting network verifier.
// No dependencies; imported by the cell and the top level.
`timescale 1ns / 1ps

package snv_pkg;

	localparam int DEF_MAX_WIRES       = 16;
	localparam int DEF_MAX_COMPARATORS = 256;
	localparam int DEF_CELLS           = 8;

	localparam int WIRE_W  = 4;
	localparam int ENTRY_W = 2 * WIRE_W;
	localparam int WCNT_W  = 5;
	localparam int CMD_W   = 2;
	localparam int IN_W    = 16;
	localparam int OUT_W   = 8;

	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BATCH,
		S_STREAM,
		S_DRAIN,
		S_FINISH
	} state_t;

	// One comparator travelling down the cell chain
	typedef struct packed {
		logic              vld;
		logic [WIRE_W-1:0] lo;
		logic [WIRE_W-1:0] hi;
	} tok_t;

endpackage

// File: design/snv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the comparator table.
`timescale 1ns / 1ps

module snv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/snv_cell.sv
// One cell of the checking chain: holds one binary pattern, applies each
// passing comparator to it and hands the comparator on. Uses snv_pkg.
`timescale 1ns / 1ps

module snv_cell #(
	parameter int MAX_WIRES = snv_pkg::DEF_MAX_WIRES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic [MAX_WIRES-1:0]       load_pattern,
	input  logic                       load_live,
	input  logic [snv_pkg::WCNT_W-1:0] n_eff,
	input  snv_pkg::tok_t              tok_in,
	output snv_pkg::tok_t              tok_out,
	output logic                       cell_ok
);
	import snv_pkg::*;

	logic [MAX_WIRES-1:0] pattern_q;
	logic                 live_q;
	tok_t                 tok_q;
	logic [MAX_WIRES-1:0] sel_lo;
	logic [MAX_WIRES-1:0] sel_hi;
	logic                 bit_lo;
	logic                 bit_hi;
	logic                 act;
	logic                 unsorted;

	always_comb begin
		for (int i = 0; i < MAX_WIRES; i++) begin
			sel_lo[i] = ({1'b0, tok_in.lo} == WIRE_W'(i) + 5'd0) && (i < (1 << WIRE_W));
			sel_hi[i] = ({1'b0, tok_in.hi} == WIRE_W'(i) + 5'd0) && (i < (1 << WIRE_W));
		end
		bit_lo = |(pattern_q & sel_lo);
		bit_hi = |(pattern_q & sel_hi);
		// skip comparators on absent wires or on a single wire
		act = tok_in.vld && ({1'b0, tok_in.hi} < n_eff) && (tok_in.lo != tok_in.hi);
	end

	always_comb begin
		unsorted = 1'b0;
		for (int i = 0; i + 1 < MAX_WIRES; i++) begin
			if ((WCNT_W'(i + 1) < n_eff) && pattern_q[i] && !pattern_q[i+1]) begin
				unsorted = 1'b1;
			end
		end
		cell_ok = !live_q || !unsorted;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pattern_q <= load_pattern;
		end else if (act && bit_lo && !bit_hi) begin
			pattern_q <= pattern_q ^ (sel_lo | sel_hi);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
			tok_q  <= '0;
		end else begin
			if (load) begin
				live_q <= load_live;
			end
			tok_q <= tok_in;
		end
	end

	assign tok_out = tok_q;

endmodule

// File: design/sorting_network_verifier_core.sv
// Top level of the sorting network verifier: command decode, comparator
// table, check sequencer and the chain of pattern cells. Uses snv_pkg,
// snv_ram and snv_cell.
//
//  channel   | dir | signals                     | contents
//  ----------+-----+-----------------------------+---------------------------------
//  s_t*      | in  | s_tvalid s_tready s_tdata   | command, wire_first, wire_second
//  m_t*      | out | m_tvalid m_tready m_tdata   | network_sorts, table_overflowed
//  cfg_*     | in  | cfg_we cfg_wdata            | wire_count
//
// Clear and append are taken while idle. A check works through the 2^n input
// patterns, n the effective wire count, in batches: the chain of CELLS cells
// works on CELLS patterns per batch while the table RAM streams one comparator a
// cycle down the chain, and the next batch loads once the chain has drained.
// Reset clears the comparator count, overflow flag and all control state.
// A finished result waits in the output register; new words are taken
// meanwhile, but a following check holds in its last state until it drains.
`timescale 1ns / 1ps

module sorting_network_verifier_core #(
	parameter int MAX_WIRES       = snv_pkg::DEF_MAX_WIRES,
	parameter int MAX_COMPARATORS = snv_pkg::DEF_MAX_COMPARATORS,
	parameter int CELLS           = snv_pkg::DEF_CELLS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [snv_pkg::WCNT_W-1:0] cfg_wdata,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// [1:0] command, [5:2] wire_first, [9:6] wire_second, rest zero
	input  logic [snv_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [0] network_sorts, [1] table_overflowed, rest zero
	output logic [snv_pkg::OUT_W-1:0]  m_tdata
);
	import snv_pkg::*;

	localparam int AW = (MAX_COMPARATORS > 1) ? $clog2(MAX_COMPARATORS) : 1;
	localparam int TW = $clog2(MAX_COMPARATORS + 1);
	localparam int PW = $clog2((1 << MAX_WIRES) + CELLS + 1);

	state_t state_q, state_d;

	logic [WCNT_W-1:0] wire_count_q;
	logic [WCNT_W-1:0] n_eff;
	logic [WCNT_W-1:0] n_q;
	logic [TW-1:0]     total_q;
	logic              overflow_q;
	logic [TW-1:0]     pos_q;
	logic [PW-1:0]     base_q;
	logic [PW-1:0]     base_next;
	logic [PW-1:0]     limit_q;
	logic              ok_q;
	logic              rd_vld_s1;
	logic              m_tvalid_q;
	logic              sorts_q;
	logic              ovf_out_q;

	logic [CMD_W-1:0]  cmd;
	logic [WIRE_W-1:0] wa;
	logic [WIRE_W-1:0] wb;
	logic [WIRE_W-1:0] wlo;
	logic [WIRE_W-1:0] whi;
	logic              accept;
	logic              do_clear;
	logic              do_append;
	logic              do_check;
	logic              ram_we;
	logic              rd_en;
	logic              load_cells;
	logic              eval;
	logic              out_load;
	logic              busy;
	logic [ENTRY_W-1:0] rdata;

	tok_t              tok_chain [CELLS+1];
	logic [CELLS-1:0]  cell_ok;
	logic [CELLS:0]    chain_vld;

	assign cmd = s_tdata[CMD_W-1:0];
	assign wa  = s_tdata[CMD_W +: WIRE_W];
	assign wb  = s_tdata[CMD_W + WIRE_W +: WIRE_W];
	assign wlo = (wa < wb) ? wa : wb;
	assign whi = (wa < wb) ? wb : wa;

	always_comb begin
		if (wire_count_q == '0) begin
			n_eff = WCNT_W'(1);
		end else if (wire_count_q > WCNT_W'(MAX_WIRES)) begin
			n_eff = WCNT_W'(MAX_WIRES);
		end else begin
			n_eff = wire_count_q;
		end
	end

	assign base_next = base_q + PW'(CELLS);

	always_comb begin
		for (int i = 0; i <= CELLS; i++) begin
			chain_vld[i] = tok_chain[i].vld;
		end
		busy = |chain_vld;
	end

	// next state and control
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		rd_en      = 1'b0;
		load_cells = 1'b0;
		eval       = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && cmd == CMD_CHECK) begin
					state_d = S_BATCH;
				end
			end
			S_BATCH: begin
				load_cells = 1'b1;
				state_d    = S_STREAM;
			end
			S_STREAM: begin
				if (pos_q != total_q) begin
					rd_en = 1'b1;
				end else begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!busy) begin
					eval    = 1'b1;
					state_d = (base_next >= limit_q) ? S_FINISH : S_BATCH;
				end
			end
			S_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign accept    = s_tvalid && s_tready;
	assign do_clear  = accept && cmd == CMD_CLEAR;
	assign do_append = accept && cmd == CMD_APPEND;
	assign do_check  = accept && cmd == CMD_CHECK;
	assign ram_we    = do_append && (total_q < TW'(MAX_COMPARATORS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wire_count_q <= WCNT_W'(1);
			total_q      <= '0;
			overflow_q   <= 1'b0;
			pos_q        <= '0;
			base_q       <= '0;
			limit_q      <= '0;
			n_q          <= WCNT_W'(1);
			ok_q         <= 1'b1;
			rd_vld_s1    <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				wire_count_q <= cfg_wdata;
			end
			if (do_clear) begin
				total_q    <= '0;
				overflow_q <= 1'b0;
			end else if (do_append) begin
				if (ram_we) begin
					total_q <= total_q + TW'(1);
				end else begin
					overflow_q <= 1'b1;
				end
			end
			if (do_check) begin
				n_q     <= n_eff;
				limit_q <= PW'(1) << n_eff;
				base_q  <= '0;
				ok_q    <= 1'b1;
			end
			if (load_cells) begin
				pos_q <= '0;
			end else if (rd_en) begin
				pos_q <= pos_q + TW'(1);
			end
			rd_vld_s1 <= rd_en;
			if (eval) begin
				ok_q   <= ok_q & (&cell_ok);
				base_q <= base_next;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sorts_q   <= ok_q;
			ovf_out_q <= overflow_q;
		end
	end

	snv_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_COMPARATORS),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (total_q[AW-1:0]),
		.wdata ({wlo, whi}),
		.re    (rd_en),
		.raddr (pos_q[AW-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		tok_chain[0].vld = rd_vld_s1;
		tok_chain[0].lo  = rdata[ENTRY_W-1:WIRE_W];
		tok_chain[0].hi  = rdata[WIRE_W-1:0];
	end

	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		logic [PW-1:0] pat_sum;

		assign pat_sum = base_q + PW'(k);

		snv_cell #(
			.MAX_WIRES (MAX_WIRES)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.load         (load_cells),
			.load_pattern (pat_sum[MAX_WIRES-1:0]),
			.load_live    (pat_sum < limit_q),
			.n_eff        (n_q),
			.tok_in       (tok_chain[k]),
			.tok_out      (tok_chain[k+1]),
			.cell_ok      (cell_ok[k])
		);
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_W - 2){1'b0}}, ovf_out_q, sorts_q};

	// an overflow is only ever flagged against a full table
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> (total_q == TW'(MAX_COMPARATORS)))
		else $error("overflow flagged with room left in table");

	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TW'(MAX_COMPARATORS))
		else $error("comparator count beyond capacity");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STREAM) |-> (pos_q <= total_q))
		else $error("stream position ran past table");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == S_FINISH))
		else $error("result raised outside check completion");

	a_drain_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BATCH) |-> !busy)
		else $error("new batch loaded with comparators in flight");

endmodule
